// File: design/bfa_pkg.sv
// shared constants, codes and types for the best-fit block allocator
package bfa_pkg;

    // table geometry
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // field widths of the stream words
    localparam int FUNC_W   = 1;
    localparam int AMT_W    = 16;
    localparam int STATUS_W = 2;
    localparam int TAG_W    = 5;
    localparam int REM_W    = 16;
    localparam int GRANT_W  = 16;
    localparam int RES_W    = STATUS_W + TAG_W + REM_W + GRANT_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

    // request kinds
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // result word, status in the lowest bits
    typedef struct packed {
        logic [GRANT_W-1:0]  grant_count;
        logic [REM_W-1:0]    remaining;
        logic [TAG_W-1:0]    block_tag;
        logic [STATUS_W-1:0] status;
    } t_result;

    // outcome of the shared compare and subtract unit
    typedef struct packed {
        logic                 fit;
        logic                 better;
        logic [SIZE_BITS-1:0] diff;
    } t_cmp;

endpackage

// File: design/bfa_ram.sv
// generic single write port ram with registered read
module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bfa_cmp.sv
// shared compare and subtract unit used by the scan and the update step
module bfa_cmp
    import bfa_pkg::*;
(
    input  logic [SIZE_BITS-1:0] i_size,
    input  logic [SIZE_BITS-1:0] i_req,
    input  logic [SIZE_BITS-1:0] i_best,
    input  logic                 i_found,
    output t_cmp                 o_cmp
);

    logic [SIZE_BITS:0] w_sub_req;
    logic [SIZE_BITS:0] w_sub_best;

    // size minus request, borrow means the block is too small
    assign w_sub_req  = {1'b0, i_size} - {1'b0, i_req};
    // size minus current best, borrow means strictly smaller
    assign w_sub_best = {1'b0, i_size} - {1'b0, i_best};

    assign o_cmp.fit    = ~w_sub_req[SIZE_BITS];
    assign o_cmp.better = ~i_found | w_sub_best[SIZE_BITS];
    assign o_cmp.diff   = w_sub_req[SIZE_BITS-1:0];

endmodule

// File: design/best_fit_block_allocator.sv
// best-fit block allocator top level: sequencer, size table and result register
//
// channel  dir  tvalid/tready         tuser        tdata
// s        in   i_s_tvalid/o_s_tready func         amount
// m        out  o_m_tvalid/i_m_tready -            status, block_tag, remaining, grant_count
//
// an add, or an allocate on an empty table, goes from the accepting step straight to the
// load of the output register; any other allocate takes the accepting step, one table
// read per cycle through the ram read port, the registered ram read, one update through
// the shared subtractor and the load, which waits while an unaccepted result is held
// a word is taken only while the sequencer is idle; a finished result waits in the
// output register and the next word may be accepted meanwhile
// synchronous active-low reset empties the table and clears the grant counter
module best_fit_block_allocator
    import bfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [AMT_W-1:0]  i_s_tdata,   // amount[15:0]
    input  logic [FUNC_W-1:0] i_s_tuser,   // func[0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata    // status[1:0], block_tag[6:2],
                                           // remaining[22:7], grant_count[38:23]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [GRANT_W-1:0]   r_grants;
    logic [SIZE_BITS-1:0] r_req;
    logic [CNT_W-1:0]     r_issue;
    logic                 r_cmp_v;
    logic                 r_cmp_last;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [SIZE_BITS-1:0] r_best_size;
    t_result              r_res;
    t_result              r_out;
    logic                 r_out_v;

    logic                 w_in_acc;
    logic [SIZE_BITS-1:0] w_amount;
    logic                 w_issue;
    logic [CNT_W-1:0]     n_issue;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [SIZE_BITS-1:0] w_wdata;
    logic [SIZE_BITS-1:0] w_rdata;
    logic [SIZE_BITS-1:0] w_cmp_size;
    t_cmp                 w_cmp;

    // input handshake
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid & o_s_tready;
    assign w_amount   = SIZE_BITS'(i_s_tdata);

    // scan read issue
    assign w_issue = (r_state == S_SCAN) && (r_issue < r_count);
    assign n_issue = r_issue + CNT_W'(1);

    // table write port: append on add, shrink chosen block on grant
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[IDX_W-1:0];
        w_wdata = w_amount;
        if (r_state == S_UPD) begin
            w_we    = r_found;
            w_waddr = r_best_idx;
            w_wdata = w_cmp.diff;
        end else if (w_in_acc && (i_s_tuser == FUNC_ADD) && (r_count != MAX_CNT)) begin
            w_we = 1'b1;
        end
    end

    bfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_sizes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // shared unit sees the read word while scanning, the best block when updating
    assign w_cmp_size = (r_state == S_UPD) ? r_best_size : w_rdata;

    bfa_cmp u_cmp (
        .i_size  (w_cmp_size),
        .i_req   (r_req),
        .i_best  (r_best_size),
        .i_found (r_found),
        .o_cmp   (w_cmp)
    );

    // sequencer, table state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_grants <= '0;
            r_cmp_v  <= 1'b0;
            r_found  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && i_m_tready && (r_state != S_OUT)) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_req      <= w_amount;
                        r_issue    <= '0;
                        r_found    <= 1'b0;
                        r_cmp_v    <= 1'b0;
                        r_cmp_last <= 1'b0;
                        if (i_s_tuser == FUNC_ADD) begin
                            r_state <= S_OUT;
                            if (r_count == MAX_CNT) begin
                                r_res <= t_result'({r_grants, REM_W'(0), TAG_W'(0),
                                                    ST_FULL});
                            end else begin
                                r_res   <= t_result'({r_grants, REM_W'(0),
                                                      TAG_W'(r_count + CNT_W'(1)),
                                                      ST_ADDED});
                                r_count <= r_count + CNT_W'(1);
                            end
                        end else if (r_count == '0) begin
                            r_res   <= t_result'({r_grants, REM_W'(0), TAG_W'(0), ST_NOFIT});
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // issue stage
                    r_cmp_v <= w_issue;
                    if (w_issue) begin
                        r_issue    <= n_issue;
                        r_cmp_idx  <= r_issue[IDX_W-1:0];
                        r_cmp_last <= (n_issue == r_count);
                    end
                    // compare stage, earliest block kept on equal sizes
                    if (r_cmp_v) begin
                        if (w_cmp.fit && w_cmp.better) begin
                            r_found     <= 1'b1;
                            r_best_idx  <= r_cmp_idx;
                            r_best_size <= w_rdata;
                        end
                        if (r_cmp_last) begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    if (r_found) begin
                        r_grants <= r_grants + GRANT_W'(1);
                        r_res    <= t_result'({r_grants + GRANT_W'(1), REM_W'(w_cmp.diff),
                                               TAG_W'(r_best_idx) + TAG_W'(1), ST_GRANTED});
                    end else begin
                        r_res <= t_result'({r_grants, REM_W'(0), TAG_W'(0), ST_NOFIT});
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_v || i_m_tready) begin
                        r_out   <= r_res;
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OUT_W'(r_out);

`ifndef SYNTHESIS
    // the table never holds more blocks than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("block count beyond table size");

    // an add into a table with room grows it by exactly one
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_s_tuser == FUNC_ADD) && (r_count != MAX_CNT))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("add did not grow the table");

    // a grant advances the counter by one and reports it
    a_grant_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && r_found)
        |=> ((r_grants == $past(r_grants) + GRANT_W'(1)) && (r_res.grant_count == r_grants)
             && (r_res.status == ST_GRANTED)))
        else $error("grant counter out of step");

    // read data is only compared while scanning
    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_v |-> (r_state == S_SCAN))
        else $error("compare outside scan");
`endif

endmodule
